// ===== hdl/mpsm_pkg.sv =====
// shared types, constants and helper functions for the multi-pattern string matcher
package mpsm_pkg;

    localparam int MAX_NODES     = 256;
    localparam int ALPHABET_SIZE = 26;
    localparam int MAX_PATTERNS  = 16;

    localparam int NODE_W   = $clog2(MAX_NODES);
    localparam int CNT_W    = NODE_W + 1;
    localparam int LETTER_W = 5;
    localparam int PAT_W    = $clog2(MAX_PATTERNS);
    localparam int PCNT_W   = PAT_W + 1;
    localparam int GOTO_DEPTH = MAX_NODES * ALPHABET_SIZE;
    localparam int GOTO_AW  = $clog2(GOTO_DEPTH);
    localparam int POS_W    = 32;

    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_FINISH = 2'd1;
    localparam logic [1:0] ACT_TEXT   = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_PHASE = 2'd2;

    typedef struct packed {
        logic [1:0]          action;
        logic [LETTER_W-1:0] letter;
        logic                end_of_pattern;
    } item_t;

    typedef struct packed {
        logic             match;
        logic [PAT_W-1:0] pattern_index;
        logic [POS_W-1:0] start_position;
        logic             last;
        logic [1:0]       status;
    } result_t;

    typedef struct packed {
        logic                    valid;
        logic [MAX_PATTERNS-1:0] mask;
        logic [POS_W-1:0]        position;
        logic [1:0]              status;
    } job_t;

    typedef struct packed {
        logic             we;
        logic [PAT_W-1:0] idx;
        logic [CNT_W-1:0] len;
    } plen_wr_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_LOAD_CHK,
        ST_MASK_WR,
        ST_R_RD,
        ST_R_CHK,
        ST_B_POP,
        ST_B_NODE,
        ST_B_FLN,
        ST_B_CRD,
        ST_B_CCHK,
        ST_B_FRD,
        ST_B_FCHK,
        ST_B_FLW,
        ST_B_M1,
        ST_B_M2,
        ST_S_CHK,
        ST_S_FL,
        ST_S_MASK,
        ST_JOB
    } state_t;

    // flat goto address: node row times alphabet plus letter
    function automatic logic [GOTO_AW-1:0] goto_addr(input logic [NODE_W-1:0] node,
                                                     input logic [LETTER_W-1:0] letter);
        goto_addr = GOTO_AW'(node) * GOTO_AW'(ALPHABET_SIZE) + GOTO_AW'(letter);
    endfunction

    // index of the lowest set bit, zero for an empty mask
    function automatic logic [PAT_W-1:0] lowest_bit(input logic [MAX_PATTERNS-1:0] mask);
        logic [PAT_W-1:0] idx;
        idx = '0;
        for (int i = MAX_PATTERNS - 1; i >= 0; i--)
        begin
            if (mask[i])
            begin
                idx = PAT_W'(i);
            end
        end
        lowest_bit = idx;
    endfunction

endpackage

// ===== hdl/mpsm_emit.sv =====
// result emitter: walks a match mask and sends one result per set bit, or one no-match result for an empty mask
module mpsm_emit (
    input  logic               clk,
    input  logic               rst_n,
    input  mpsm_pkg::job_t     job,
    output logic               job_ready,
    input  mpsm_pkg::plen_wr_t plen_wr,
    output mpsm_pkg::result_t  result,
    output logic               result_valid,
    input  logic               result_stall
);

    logic                              busy_reg;
    logic [mpsm_pkg::MAX_PATTERNS-1:0] mask_reg;
    logic [mpsm_pkg::POS_W-1:0]        pos_reg;
    logic [1:0]                        status_reg;
    logic [mpsm_pkg::CNT_W-1:0]        plen_reg [mpsm_pkg::MAX_PATTERNS];
    logic                              out_valid_reg;
    mpsm_pkg::result_t                 out_reg;

    logic                              advance;
    logic [mpsm_pkg::PAT_W-1:0]        pick;
    logic [mpsm_pkg::MAX_PATTERNS-1:0] rest;
    mpsm_pkg::result_t                 res_next;

    assign job_ready    = !busy_reg;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign advance      = busy_reg && (!out_valid_reg || !result_stall);

    always_comb
    begin
        pick = mpsm_pkg::lowest_bit(mask_reg);
        rest = mask_reg & ~(mpsm_pkg::MAX_PATTERNS'(1) << pick);
        res_next.status = status_reg;
        if (mask_reg == '0)
        begin
            res_next.match          = 1'b0;
            res_next.pattern_index  = '0;
            res_next.start_position = '0;
            res_next.last           = 1'b1;
        end
        else
        begin
            res_next.match          = 1'b1;
            res_next.pattern_index  = pick;
            res_next.start_position = pos_reg - mpsm_pkg::POS_W'(plen_reg[pick])
                                      + mpsm_pkg::POS_W'(1);
            res_next.last           = (rest == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (plen_wr.we)
        begin
            plen_reg[plen_wr.idx] <= plen_wr.len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            mask_reg      <= '0;
            pos_reg       <= '0;
            status_reg    <= mpsm_pkg::STATUS_OK;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (job.valid && !busy_reg)
            begin
                busy_reg   <= 1'b1;
                mask_reg   <= job.mask;
                pos_reg    <= job.position;
                status_reg <= job.status;
            end
            if (advance)
            begin
                out_reg       <= res_next;
                out_valid_reg <= 1'b1;
                mask_reg      <= rest;
                busy_reg      <= (mask_reg != '0) && (rest != '0);
            end
            else if (out_valid_reg && !result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== hdl/multi_pattern_string_matcher_top.sv =====
// top level of the multi-pattern string matcher (trie, failure links, text search)
// usage:
//   item channel (item_valid / item_stall / item) carries one request per item:
//   a pattern letter to load, the finish request, or a text letter
//   result channel (result_valid / result_stall / result) returns one or more
//   results per request; the final one of each request has last set
// after reset the goto table and output masks are swept clear, one entry a
// cycle; item_stall stays high during the sweep
// steps per request:
//   load letter: goto check; ending a pattern adds a mask read-modify-write
//   text letter: goto check, one failure-link hop per miss, then the mask read
//   finish: root edges, then a breadth-first pass over the queued nodes
//   wrong phase or out-of-range item: goes straight to the result job
//   results leave one per cycle from the emitter while result_stall is low;
//   a new request is accepted while earlier results are still draining
// a stalled result holds in the output register; the emitter and then the
// request path back up, so nothing is lost while the receiver stalls
module multi_pattern_string_matcher_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  mpsm_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output mpsm_pkg::result_t result
);

    localparam int NW  = mpsm_pkg::NODE_W;
    localparam int CW  = mpsm_pkg::CNT_W;
    localparam int LW  = mpsm_pkg::LETTER_W;
    localparam int AW  = mpsm_pkg::GOTO_AW;
    localparam int MP  = mpsm_pkg::MAX_PATTERNS;
    localparam int PW  = mpsm_pkg::POS_W;

    // fsm and control
    mpsm_pkg::state_t state_reg, state_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic [1:0]       act_reg, act_next;
    logic [LW-1:0]    let_reg, let_next;
    logic             eop_reg, eop_next;
    logic             phase_reg, phase_next;

    // dictionary load state
    logic [CW-1:0]             node_count_reg, node_count_next;
    logic [mpsm_pkg::PCNT_W-1:0] pat_count_reg, pat_count_next;
    logic [NW-1:0]             load_node_reg, load_node_next;
    logic [CW-1:0]             load_len_reg, load_len_next;

    // search state
    logic [NW-1:0] cur_reg, cur_next;
    logic [PW-1:0] pos_reg, pos_next;

    // link build scratch
    logic [CW-1:0] head_reg, head_next;
    logic [CW-1:0] tail_reg, tail_next;
    logic [LW-1:0] c_reg, c_next;
    logic [NW-1:0] bnode_reg, bnode_next;
    logic [NW-1:0] flnode_reg, flnode_next;
    logic [NW-1:0] child_reg, child_next;
    logic [NW-1:0] walk_reg, walk_next;
    logic [NW-1:0] flr_reg, flr_next;
    logic [MP-1:0] maska_reg, maska_next;

    // job handed to the emitter
    logic [MP-1:0] job_mask_reg, job_mask_next;
    logic [PW-1:0] job_pos_reg, job_pos_next;
    logic [1:0]    job_status_reg, job_status_next;

    mpsm_pkg::job_t     job;
    logic               job_ready;
    mpsm_pkg::plen_wr_t plen_wr;

    // goto table: valid bit plus child node
    logic [NW:0]   goto_mem [mpsm_pkg::GOTO_DEPTH];
    logic          goto_we;
    logic [AW-1:0] goto_wa, goto_ra;
    logic [NW:0]   goto_wd, goto_rd;

    // failure links
    logic [NW-1:0] fl_mem [mpsm_pkg::MAX_NODES];
    logic          fl_we;
    logic [NW-1:0] fl_wa, fl_ra, fl_wd, fl_rd;

    // output masks
    logic [MP-1:0] mask_mem [mpsm_pkg::MAX_NODES];
    logic          mask_we;
    logic [NW-1:0] mask_wa, mask_ra;
    logic [MP-1:0] mask_wd, mask_rd;

    // breadth-first queue
    logic [NW-1:0] q_mem [mpsm_pkg::MAX_NODES];
    logic          q_we;
    logic [NW-1:0] q_wa, q_ra, q_wd, q_rd;

    logic          goto_hit;
    logic          letter_bad;
    logic          load_full;
    logic          last_letter;

    assign goto_hit    = goto_rd[NW];
    assign letter_bad  = (let_reg >= LW'(mpsm_pkg::ALPHABET_SIZE));
    assign load_full   = pat_count_reg[mpsm_pkg::PAT_W]
                         || (!goto_hit && node_count_reg == CW'(mpsm_pkg::MAX_NODES));
    assign last_letter = (c_reg == LW'(mpsm_pkg::ALPHABET_SIZE - 1));

    // memories
    always_ff @(posedge clk)
    begin
        if (goto_we)
        begin
            goto_mem[goto_wa] <= goto_wd;
        end
        goto_rd <= goto_mem[goto_ra];
    end

    always_ff @(posedge clk)
    begin
        if (fl_we)
        begin
            fl_mem[fl_wa] <= fl_wd;
        end
        fl_rd <= fl_mem[fl_ra];
    end

    always_ff @(posedge clk)
    begin
        if (mask_we)
        begin
            mask_mem[mask_wa] <= mask_wd;
        end
        mask_rd <= mask_mem[mask_ra];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[q_wa] <= q_wd;
        end
        q_rd <= q_mem[q_ra];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mpsm_pkg::ST_CLEAR:
            begin
                if (clr_reg == AW'(mpsm_pkg::GOTO_DEPTH - 1))
                begin
                    state_next = mpsm_pkg::ST_IDLE;
                end
            end
            mpsm_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = mpsm_pkg::ST_DECODE;
                end
            end
            mpsm_pkg::ST_DECODE:
            begin
                if (act_reg == mpsm_pkg::ACT_LOAD && !phase_reg && !letter_bad)
                begin
                    state_next = mpsm_pkg::ST_LOAD_CHK;
                end
                else if (act_reg == mpsm_pkg::ACT_FINISH && !phase_reg)
                begin
                    state_next = mpsm_pkg::ST_R_RD;
                end
                else if (act_reg == mpsm_pkg::ACT_TEXT && phase_reg && !letter_bad)
                begin
                    state_next = mpsm_pkg::ST_S_CHK;
                end
                else
                begin
                    state_next = mpsm_pkg::ST_JOB;
                end
            end
            mpsm_pkg::ST_LOAD_CHK:
            begin
                if (!load_full && eop_reg)
                begin
                    state_next = mpsm_pkg::ST_MASK_WR;
                end
                else
                begin
                    state_next = mpsm_pkg::ST_JOB;
                end
            end
            mpsm_pkg::ST_MASK_WR: state_next = mpsm_pkg::ST_JOB;
            mpsm_pkg::ST_R_RD:    state_next = mpsm_pkg::ST_R_CHK;
            mpsm_pkg::ST_R_CHK:
            begin
                state_next = last_letter ? mpsm_pkg::ST_B_POP : mpsm_pkg::ST_R_RD;
            end
            mpsm_pkg::ST_B_POP:
            begin
                state_next = (head_reg < tail_reg) ? mpsm_pkg::ST_B_NODE : mpsm_pkg::ST_JOB;
            end
            mpsm_pkg::ST_B_NODE: state_next = mpsm_pkg::ST_B_FLN;
            mpsm_pkg::ST_B_FLN:  state_next = mpsm_pkg::ST_B_CRD;
            mpsm_pkg::ST_B_CRD:  state_next = mpsm_pkg::ST_B_CCHK;
            mpsm_pkg::ST_B_CCHK:
            begin
                if (goto_hit)
                begin
                    state_next = mpsm_pkg::ST_B_FRD;
                end
                else
                begin
                    state_next = last_letter ? mpsm_pkg::ST_B_POP : mpsm_pkg::ST_B_CRD;
                end
            end
            mpsm_pkg::ST_B_FRD: state_next = mpsm_pkg::ST_B_FCHK;
            mpsm_pkg::ST_B_FCHK:
            begin
                state_next = goto_hit ? mpsm_pkg::ST_B_M1 : mpsm_pkg::ST_B_FLW;
            end
            mpsm_pkg::ST_B_FLW: state_next = mpsm_pkg::ST_B_FRD;
            mpsm_pkg::ST_B_M1:  state_next = mpsm_pkg::ST_B_M2;
            mpsm_pkg::ST_B_M2:
            begin
                state_next = last_letter ? mpsm_pkg::ST_B_POP : mpsm_pkg::ST_B_CRD;
            end
            mpsm_pkg::ST_S_CHK:
            begin
                state_next = goto_hit ? mpsm_pkg::ST_S_MASK : mpsm_pkg::ST_S_FL;
            end
            mpsm_pkg::ST_S_FL:   state_next = mpsm_pkg::ST_S_CHK;
            mpsm_pkg::ST_S_MASK: state_next = mpsm_pkg::ST_JOB;
            mpsm_pkg::ST_JOB:
            begin
                if (job_ready)
                begin
                    state_next = mpsm_pkg::ST_IDLE;
                end
            end
            default: state_next = mpsm_pkg::ST_CLEAR;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        clr_next        = clr_reg;
        act_next        = act_reg;
        let_next        = let_reg;
        eop_next        = eop_reg;
        phase_next      = phase_reg;
        node_count_next = node_count_reg;
        pat_count_next  = pat_count_reg;
        load_node_next  = load_node_reg;
        load_len_next   = load_len_reg;
        cur_next        = cur_reg;
        pos_next        = pos_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        c_next          = c_reg;
        bnode_next      = bnode_reg;
        flnode_next     = flnode_reg;
        child_next      = child_reg;
        walk_next       = walk_reg;
        flr_next        = flr_reg;
        maska_next      = maska_reg;
        job_mask_next   = job_mask_reg;
        job_pos_next    = job_pos_reg;
        job_status_next = job_status_reg;

        goto_we = 1'b0;
        goto_wa = '0;
        goto_wd = '0;
        goto_ra = '0;
        fl_we   = 1'b0;
        fl_wa   = '0;
        fl_wd   = '0;
        fl_ra   = '0;
        mask_we = 1'b0;
        mask_wa = '0;
        mask_wd = '0;
        mask_ra = '0;
        q_we    = 1'b0;
        q_wa    = '0;
        q_wd    = '0;
        q_ra    = '0;

        plen_wr.we  = 1'b0;
        plen_wr.idx = pat_count_reg[mpsm_pkg::PAT_W-1:0];
        plen_wr.len = load_len_reg + CW'(1);

        item_stall = (state_reg != mpsm_pkg::ST_IDLE);
        job.valid    = (state_reg == mpsm_pkg::ST_JOB);
        job.mask     = job_mask_reg;
        job.position = job_pos_reg;
        job.status   = job_status_reg;

        case (state_reg)
            mpsm_pkg::ST_CLEAR:
            begin
                goto_we = 1'b1;
                goto_wa = clr_reg;
                goto_wd = '0;
                if (clr_reg < AW'(mpsm_pkg::MAX_NODES))
                begin
                    mask_we = 1'b1;
                    mask_wa = clr_reg[NW-1:0];
                    mask_wd = '0;
                end
                clr_next = clr_reg + AW'(1);
            end
            mpsm_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    act_next = item.action;
                    let_next = item.letter;
                    eop_next = item.end_of_pattern;
                end
            end
            mpsm_pkg::ST_DECODE:
            begin
                job_mask_next   = '0;
                job_pos_next    = '0;
                job_status_next = mpsm_pkg::STATUS_OK;
                if (act_reg == mpsm_pkg::ACT_LOAD && !phase_reg)
                begin
                    if (letter_bad)
                    begin
                        job_status_next = mpsm_pkg::STATUS_PHASE;
                    end
                    goto_ra = mpsm_pkg::goto_addr(load_node_reg, let_reg);
                end
                else if (act_reg == mpsm_pkg::ACT_FINISH && !phase_reg)
                begin
                    c_next    = '0;
                    head_next = '0;
                    tail_next = '0;
                end
                else if (act_reg == mpsm_pkg::ACT_TEXT && phase_reg)
                begin
                    if (letter_bad)
                    begin
                        // out-of-range text letter drops back to the root
                        cur_next     = '0;
                        job_pos_next = pos_reg;
                        pos_next     = pos_reg + PW'(1);
                    end
                    walk_next = cur_reg;
                    goto_ra   = mpsm_pkg::goto_addr(cur_reg, let_reg);
                end
                else
                begin
                    job_status_next = mpsm_pkg::STATUS_PHASE;
                end
            end
            mpsm_pkg::ST_LOAD_CHK:
            begin
                if (load_full)
                begin
                    job_status_next = mpsm_pkg::STATUS_FULL;
                    if (eop_reg)
                    begin
                        load_node_next = '0;
                        load_len_next  = '0;
                    end
                end
                else
                begin
                    if (!goto_hit)
                    begin
                        goto_we         = 1'b1;
                        goto_wa         = mpsm_pkg::goto_addr(load_node_reg, let_reg);
                        goto_wd         = {1'b1, node_count_reg[NW-1:0]};
                        node_count_next = node_count_reg + CW'(1);
                    end
                    if (eop_reg)
                    begin
                        child_next     = goto_hit ? goto_rd[NW-1:0] : node_count_reg[NW-1:0];
                        mask_ra        = child_next;
                        maska_next     = MP'(1) << pat_count_reg[mpsm_pkg::PAT_W-1:0];
                        plen_wr.we     = 1'b1;
                        pat_count_next = pat_count_reg + mpsm_pkg::PCNT_W'(1);
                        load_node_next = '0;
                        load_len_next  = '0;
                    end
                    else
                    begin
                        load_node_next = goto_hit ? goto_rd[NW-1:0] : node_count_reg[NW-1:0];
                        load_len_next  = load_len_reg + CW'(1);
                    end
                end
            end
            mpsm_pkg::ST_MASK_WR:
            begin
                mask_we = 1'b1;
                mask_wa = child_reg;
                mask_wd = mask_rd | maska_reg;
            end
            mpsm_pkg::ST_R_RD:
            begin
                goto_ra = mpsm_pkg::goto_addr('0, c_reg);
            end
            mpsm_pkg::ST_R_CHK:
            begin
                if (!goto_hit)
                begin
                    // root gets a self edge for every missing letter
                    goto_we = 1'b1;
                    goto_wa = mpsm_pkg::goto_addr('0, c_reg);
                    goto_wd = {1'b1, NW'(0)};
                end
                else if (goto_rd[NW-1:0] != '0 && tail_reg < CW'(mpsm_pkg::MAX_NODES))
                begin
                    fl_we     = 1'b1;
                    fl_wa     = goto_rd[NW-1:0];
                    fl_wd     = '0;
                    q_we      = 1'b1;
                    q_wa      = tail_reg[NW-1:0];
                    q_wd      = goto_rd[NW-1:0];
                    tail_next = tail_reg + CW'(1);
                end
                c_next = c_reg + LW'(1);
            end
            mpsm_pkg::ST_B_POP:
            begin
                if (head_reg < tail_reg)
                begin
                    q_ra = head_reg[NW-1:0];
                end
                else
                begin
                    load_node_next = '0;
                    load_len_next  = '0;
                    cur_next       = '0;
                    pos_next       = '0;
                    phase_next     = 1'b1;
                end
            end
            mpsm_pkg::ST_B_NODE:
            begin
                bnode_next = q_rd;
                head_next  = head_reg + CW'(1);
                fl_ra      = q_rd;
            end
            mpsm_pkg::ST_B_FLN:
            begin
                flnode_next = fl_rd;
                c_next      = '0;
            end
            mpsm_pkg::ST_B_CRD:
            begin
                goto_ra = mpsm_pkg::goto_addr(bnode_reg, c_reg);
            end
            mpsm_pkg::ST_B_CCHK:
            begin
                if (goto_hit)
                begin
                    child_next = goto_rd[NW-1:0];
                    walk_next  = flnode_reg;
                end
                else
                begin
                    c_next = c_reg + LW'(1);
                end
            end
            mpsm_pkg::ST_B_FRD:
            begin
                goto_ra = mpsm_pkg::goto_addr(walk_reg, c_reg);
            end
            mpsm_pkg::ST_B_FCHK:
            begin
                if (goto_hit)
                begin
                    flr_next = goto_rd[NW-1:0];
                    mask_ra  = goto_rd[NW-1:0];
                end
                else
                begin
                    fl_ra = walk_reg;
                end
            end
            mpsm_pkg::ST_B_FLW:
            begin
                walk_next = fl_rd;
            end
            mpsm_pkg::ST_B_M1:
            begin
                maska_next = mask_rd;
                mask_ra    = child_reg;
            end
            mpsm_pkg::ST_B_M2:
            begin
                mask_we = 1'b1;
                mask_wa = child_reg;
                mask_wd = mask_rd | maska_reg;
                fl_we   = 1'b1;
                fl_wa   = child_reg;
                fl_wd   = flr_reg;
                if (tail_reg < CW'(mpsm_pkg::MAX_NODES))
                begin
                    q_we      = 1'b1;
                    q_wa      = tail_reg[NW-1:0];
                    q_wd      = child_reg;
                    tail_next = tail_reg + CW'(1);
                end
                c_next = c_reg + LW'(1);
            end
            mpsm_pkg::ST_S_CHK:
            begin
                if (goto_hit)
                begin
                    walk_next = goto_rd[NW-1:0];
                    mask_ra   = goto_rd[NW-1:0];
                end
                else
                begin
                    fl_ra = walk_reg;
                end
            end
            mpsm_pkg::ST_S_FL:
            begin
                walk_next = fl_rd;
                goto_ra   = mpsm_pkg::goto_addr(fl_rd, let_reg);
            end
            mpsm_pkg::ST_S_MASK:
            begin
                cur_next      = walk_reg;
                job_mask_next = mask_rd;
                job_pos_next  = pos_reg;
                pos_next      = pos_reg + PW'(1);
            end
            mpsm_pkg::ST_JOB:
            begin
                job_status_next = job_status_reg;
            end
            default:
            begin
                clr_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mpsm_pkg::ST_CLEAR;
            clr_reg        <= '0;
            act_reg        <= '0;
            let_reg        <= '0;
            eop_reg        <= 1'b0;
            phase_reg      <= 1'b0;
            node_count_reg <= CW'(1);
            pat_count_reg  <= '0;
            load_node_reg  <= '0;
            load_len_reg   <= '0;
            cur_reg        <= '0;
            pos_reg        <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            c_reg          <= '0;
            bnode_reg      <= '0;
            flnode_reg     <= '0;
            child_reg      <= '0;
            walk_reg       <= '0;
            flr_reg        <= '0;
            maska_reg      <= '0;
            job_mask_reg   <= '0;
            job_pos_reg    <= '0;
            job_status_reg <= mpsm_pkg::STATUS_OK;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            act_reg        <= act_next;
            let_reg        <= let_next;
            eop_reg        <= eop_next;
            phase_reg      <= phase_next;
            node_count_reg <= node_count_next;
            pat_count_reg  <= pat_count_next;
            load_node_reg  <= load_node_next;
            load_len_reg   <= load_len_next;
            cur_reg        <= cur_next;
            pos_reg        <= pos_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            c_reg          <= c_next;
            bnode_reg      <= bnode_next;
            flnode_reg     <= flnode_next;
            child_reg      <= child_next;
            walk_reg       <= walk_next;
            flr_reg        <= flr_next;
            maska_reg      <= maska_next;
            job_mask_reg   <= job_mask_next;
            job_pos_reg    <= job_pos_next;
            job_status_reg <= job_status_next;
        end
    end

    mpsm_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .job          (job),
        .job_ready    (job_ready),
        .plen_wr      (plen_wr),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

`ifndef ASSERT_OFF
    // an accepted request always leaves idle on the next edge
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> (state_reg != mpsm_pkg::ST_IDLE))
        else $error("accepted request did not leave idle");

    // the search walk never needs the failure link of the root
    a_no_root_hop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mpsm_pkg::ST_S_CHK && !goto_hit) |-> (walk_reg != '0))
        else $error("failure walk tried to leave the root");

    // node allocation stays within the table
    a_node_bound: assert property (@(posedge clk) disable iff (!rst_n)
        node_count_reg <= CW'(mpsm_pkg::MAX_NODES))
        else $error("node count beyond table size");

    // once searching, the dictionary is never written again
    a_frozen_dict: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg && $past(phase_reg)) |-> $stable(node_count_reg))
        else $error("dictionary changed during search");
`endif

endmodule
